FILE: design/jpt_pkg.sv
// package for the json path tokenizer: character classes, parser phases,
// result kinds and the token and result records shared by every module but the fifo
`timescale 1ns / 1ps

package jpt_pkg;

  localparam int unsigned DefMaxSlots   = 8;
  localparam int unsigned DefMaxPathLen = 4096;

  localparam int unsigned FieldW    = 12;
  localparam int unsigned IndexW    = 31;
  localparam int unsigned TokQDepth = 2;
  localparam int unsigned ResDepth  = 4;
  localparam int unsigned ResPtrW   = $clog2(ResDepth);
  localparam int unsigned ResCntW   = $clog2(ResDepth + 1);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [3:0] {
    CC_NUL,
    CC_SLASH,
    CC_LBRACK,
    CC_RBRACK,
    CC_STAR,
    CC_SPACE,
    CC_PLUS,
    CC_MINUS,
    CC_DIGIT,
    CC_OTHER
  } char_cls_e;

  typedef enum logic [3:0] {
    PH_SLASH,
    PH_SEC,
    PH_NAME,
    PH_OPEN,
    PH_WS,
    PH_STAR,
    PH_NUM,
    PH_AFTER,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    RK_SECTION,
    RK_DONE,
    RK_SYNTAX,
    RK_TOOMANY,
    RK_TOOLONG
  } result_kind_e;

  typedef struct packed {
    char_cls_e          cls;
    logic [3:0]         digit;
    logic               too_long;
    logic [FieldW-1:0]  pos;
  } tok_t;

  localparam int unsigned TokW = $bits(tok_t);

  typedef struct packed {
    result_kind_e       result_kind;
    logic [2:0]         section_number;
    logic [FieldW-1:0]  name_start;
    logic [FieldW-1:0]  name_len;
    logic               has_index;
    logic               all_indexes;
    logic [IndexW-1:0]  index_value;
    logic [2:0]         section_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } res_push_t;

endpackage

FILE: design/jpt_if.sv
// channel interfaces: path characters in, tokenizer results out
// depends on jpt_pkg
`timescale 1ns / 1ps

interface jpt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface jpt_result_if;
  import jpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          result_kind;
  logic [2:0]          section_number;
  logic [FieldW-1:0]   name_start;
  logic [FieldW-1:0]   name_len;
  logic                has_index;
  logic                all_indexes;
  logic [IndexW-1:0]   index_value;
  logic [2:0]          section_count;
  logic                last;

  modport source (output valid, output result_kind, output section_number,
                  output name_start, output name_len, output has_index,
                  output all_indexes, output index_value, output section_count,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input section_number,
                  input name_start, input name_len, input has_index,
                  input all_indexes, input index_value, input section_count,
                  input last, output ready);
endinterface

FILE: design/jpt_fifo.sv
// small flop based fifo that carries classified characters
// depends on nothing but its parameters
`timescale 1ns / 1ps

module jpt_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: design/jpt_front.sv
// front end: accepts path characters, classifies them and tracks the offset
// depends on jpt_pkg and jpt_char_if
`timescale 1ns / 1ps

module jpt_front
  import jpt_pkg::*;
#(
  parameter int unsigned MAX_PATH_LEN = DefMaxPathLen
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jpt_char_if.sink      char_i,
  input  logic          full_i,
  output logic          push_o,
  output tok_t          tok_o
);

  localparam int unsigned PosW = $clog2(MAX_PATH_LEN + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      ch;
  logic [7:0]      dig;
  char_cls_e       cls;

  assign ch           = char_i.ch;
  assign char_i.ready = !full_i;
  assign push_o       = char_i.valid && !full_i;
  assign dig          = ch - ChZero;

  always_comb begin
    priority if (ch == ChNul)                   cls = CC_NUL;
    else if (ch == ChSlash)                     cls = CC_SLASH;
    else if (ch == ChLBrack)                    cls = CC_LBRACK;
    else if (ch == ChRBrack)                    cls = CC_RBRACK;
    else if (ch == ChStar)                      cls = CC_STAR;
    else if (ch == ChPlus)                      cls = CC_PLUS;
    else if (ch == ChMinus)                     cls = CC_MINUS;
    else if (ch == ChSpace || (ch >= ChTab && ch <= ChCr)) cls = CC_SPACE;
    else if (ch >= ChZero && ch <= ChNine)      cls = CC_DIGIT;
    else                                        cls = CC_OTHER;
  end

  always_comb begin
    tok_o.cls      = cls;
    tok_o.digit    = dig[3:0];
    tok_o.too_long = (cls != CC_NUL) && (pos_q == PosW'(MAX_PATH_LEN));
    tok_o.pos      = FieldW'(pos_q);
  end

  // offset counts nonzero characters since the last terminator, saturating
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (cls == CC_NUL) begin
        pos_d = '0;
      end else if (pos_q != PosW'(MAX_PATH_LEN)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: design/jpt_back.sv
// back end: path parser state machine, builds section, done and error results
// depends on jpt_pkg
`timescale 1ns / 1ps

module jpt_back
  import jpt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DefMaxSlots
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tok_valid_i,
  input  tok_t      tok_i,
  input  logic      space_i,
  output logic      pop_o,
  output res_push_t push_o
);

  localparam int unsigned SecW = $clog2(MAX_SLOTS);

  phase_e              phase_q, phase_d;
  logic [SecW-1:0]     sec_q, sec_d;
  logic [FieldW-1:0]   start_q, start_d;
  logic [FieldW-1:0]   len_q, len_d;
  logic                has_q, has_d;
  logic                all_q, all_d;
  logic                neg_q, neg_d;
  logic                seen_q, seen_d;
  logic [IndexW-1:0]   acc_q, acc_d;

  logic                fire;
  logic                nul;
  logic                last_slot;
  logic [IndexW+3:0]   acc_next;
  logic [SecW:0]       sec_inc;
  logic                do_fail;
  logic                do_finish;
  logic                do_done;
  logic                reset_all;
  result_kind_e        fail_kind;

  assign fire      = tok_valid_i && space_i;
  assign pop_o     = fire;
  assign nul       = (tok_i.cls == CC_NUL);
  assign last_slot = (sec_q == SecW'(MAX_SLOTS - 1));
  assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                   + {(IndexW)'(0), tok_i.digit};
  assign sec_inc   = {1'b0, sec_q} + (SecW + 1)'(1);

  always_comb begin
    phase_d   = phase_q;
    sec_d     = sec_q;
    start_d   = start_q;
    len_d     = len_q;
    has_d     = has_q;
    all_d     = all_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    push_o    = '0;
    do_fail   = 1'b0;
    do_finish = 1'b0;
    do_done   = 1'b0;
    reset_all = 1'b0;
    fail_kind = RK_SYNTAX;

    if (fire) begin
      if (phase_q == PH_SKIP) begin
        reset_all = nul;
      end else if (tok_i.too_long) begin
        do_fail   = 1'b1;
        fail_kind = RK_TOOLONG;
      end else begin
        unique case (phase_q)
          PH_SLASH: begin
            if (tok_i.cls == CC_SLASH) phase_d = PH_SEC;
            else                       do_fail = 1'b1;
          end
          PH_SEC: begin
            if (nul) begin
              do_done = 1'b1;
            end else if (tok_i.cls == CC_SLASH) begin
              do_fail = 1'b1;
            end else begin
              start_d = tok_i.pos;
              neg_d   = 1'b0;
              seen_d  = 1'b0;
              acc_d   = '0;
              all_d   = 1'b1;
              if (tok_i.cls == CC_LBRACK) begin
                len_d   = '0;
                has_d   = 1'b1;
                phase_d = PH_OPEN;
              end else begin
                len_d   = FieldW'(1);
                has_d   = 1'b0;
                phase_d = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            if (nul || tok_i.cls == CC_SLASH) begin
              do_finish = 1'b1;
            end else if (tok_i.cls == CC_LBRACK) begin
              has_d   = 1'b1;
              all_d   = 1'b1;
              neg_d   = 1'b0;
              seen_d  = 1'b0;
              acc_d   = '0;
              phase_d = PH_OPEN;
            end else begin
              len_d = len_q + FieldW'(1);
            end
          end
          PH_OPEN, PH_WS: begin
            priority if (phase_q == PH_OPEN && tok_i.cls == CC_RBRACK) begin
              phase_d = PH_AFTER;
            end else if (phase_q == PH_OPEN && tok_i.cls == CC_STAR) begin
              phase_d = PH_STAR;
            end else if (tok_i.cls == CC_SPACE) begin
              phase_d = PH_WS;
            end else if (tok_i.cls == CC_PLUS || tok_i.cls == CC_MINUS) begin
              neg_d   = (tok_i.cls == CC_MINUS);
              phase_d = PH_NUM;
            end else if (tok_i.cls == CC_DIGIT) begin
              seen_d  = 1'b1;
              acc_d   = IndexW'(tok_i.digit);
              phase_d = PH_NUM;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_STAR: begin
            if (tok_i.cls == CC_RBRACK) phase_d = PH_AFTER;
            else                        do_fail = 1'b1;
          end
          PH_NUM: begin
            if (tok_i.cls == CC_DIGIT) begin
              if ((neg_q && tok_i.digit != 4'd0) || acc_next[IndexW+3:IndexW] != '0) begin
                do_fail = 1'b1;
              end else begin
                acc_d  = acc_next[IndexW-1:0];
                seen_d = 1'b1;
              end
            end else if (tok_i.cls == CC_RBRACK && seen_q) begin
              all_d   = 1'b0;
              phase_d = PH_AFTER;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_AFTER: begin
            if (nul || tok_i.cls == CC_SLASH) do_finish = 1'b1;
            else                              do_fail   = 1'b1;
          end
          default: do_fail = 1'b1;
        endcase
      end
    end

    if (do_finish) begin
      if (last_slot) begin
        do_fail   = 1'b1;
        fail_kind = RK_TOOMANY;
      end else begin
        push_o.n                 = 2'd1;
        push_o.r0.result_kind    = RK_SECTION;
        push_o.r0.section_number = 3'(sec_q);
        push_o.r0.name_start     = start_q;
        push_o.r0.name_len       = len_q;
        push_o.r0.has_index      = has_q;
        push_o.r0.all_indexes    = all_q;
        push_o.r0.index_value    = all_q ? '0 : acc_q;
        if (nul) begin
          push_o.n                = 2'd2;
          push_o.r1.result_kind   = RK_DONE;
          push_o.r1.section_count = 3'(sec_inc);
          push_o.r1.last          = 1'b1;
          reset_all               = 1'b1;
        end else begin
          sec_d   = sec_inc[SecW-1:0];
          start_d = '0;
          len_d   = '0;
          has_d   = 1'b0;
          all_d   = 1'b1;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
          acc_d   = '0;
          phase_d = PH_SEC;
        end
      end
    end

    if (do_done) begin
      push_o.n                = 2'd1;
      push_o.r0.result_kind   = RK_DONE;
      push_o.r0.section_count = 3'(sec_q);
      push_o.r0.last          = 1'b1;
      reset_all               = 1'b1;
    end

    if (do_fail) begin
      push_o.n              = 2'd1;
      push_o.r0             = '0;
      push_o.r0.result_kind = fail_kind;
      push_o.r0.last        = 1'b1;
      if (nul) reset_all = 1'b1;
      else     phase_d   = PH_SKIP;
    end

    if (reset_all) begin
      phase_d = PH_SLASH;
      sec_d   = '0;
      start_d = '0;
      len_d   = '0;
      has_d   = 1'b0;
      all_d   = 1'b1;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      acc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SLASH;
      sec_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      has_q   <= 1'b0;
      all_q   <= 1'b1;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sec_q   <= sec_d;
      start_q <= start_d;
      len_q   <= len_d;
      has_q   <= has_d;
      all_q   <= all_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
    end
  end

endmodule

FILE: design/jpt_res_buf.sv
// result buffer: takes up to two results a cycle, hands out one per transfer
// depends on jpt_pkg and jpt_result_if
`timescale 1ns / 1ps

module jpt_res_buf
  import jpt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  res_push_t     push_i,
  output logic          space_o,
  jpt_result_if.source  result_o
);

  result_t              mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [ResCntW-1:0]   cnt_q, cnt_d;
  logic                 pop;
  result_t              head;

  assign space_o = (cnt_q <= ResCntW'(ResDepth - 2));
  assign pop     = result_o.valid && result_o.ready;
  assign head    = mem_q[rd_q];

  assign result_o.valid          = (cnt_q != '0);
  assign result_o.result_kind    = head.result_kind;
  assign result_o.section_number = head.section_number;
  assign result_o.name_start     = head.name_start;
  assign result_o.name_len       = head.name_len;
  assign result_o.has_index      = head.has_index;
  assign result_o.all_indexes    = head.all_indexes;
  assign result_o.index_value    = head.index_value;
  assign result_o.section_count  = head.section_count;
  assign result_o.last           = head.last;

  always_comb begin
    wr_d  = wr_q + ResPtrW'(push_i.n);
    rd_d  = pop ? rd_q + ResPtrW'(1) : rd_q;
    cnt_d = cnt_q + ResCntW'(push_i.n) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + ResPtrW'(1)] <= push_i.r1;
    end
  end

endmodule

FILE: design/json_path_tokenizer.sv
// top level of the json path tokenizer: front end, character queue, parser
// and result buffer; depends on jpt_pkg, jpt_if and all jpt_* modules
//
// usage: path characters arrive on char_i, one per transfer, with a zero
// character ending each path. results leave on result_o: one per finished
// section (offset, name length, index flags and value), then a done result
// with the section count, or a single error result (bad syntax, too many
// sections, path too long). the final result of every path has last set.
// after an error the remaining characters up to the terminator give nothing.
// throughput: one character per cycle while the result buffer has room, set
// by the parser which retires one queued character each cycle. a character
// that ends the path and its last section yields two results, drained one
// per cycle from the result buffer. both queues are registered. when the
// receiver stalls, the result buffer fills, the parser holds and the
// character queue backs up to char_i.ready; nothing is dropped.
// reset clears the parser to expect a leading slash and empties both queues.
`timescale 1ns / 1ps

module json_path_tokenizer
  import jpt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS    = DefMaxSlots,
  parameter int unsigned MAX_PATH_LEN = DefMaxPathLen
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jpt_char_if.sink      char_i,
  jpt_result_if.source  result_o
);

  logic             tq_push;
  logic             tq_full;
  logic             tq_pop;
  logic             tq_valid;
  tok_t             tq_wtok;
  logic [TokW-1:0]  tq_rdata;
  logic             rb_space;
  res_push_t        rb_push;

  jpt_front #(
    .MAX_PATH_LEN(MAX_PATH_LEN)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .full_i (tq_full),
    .push_o (tq_push),
    .tok_o  (tq_wtok)
  );

  jpt_fifo #(
    .Width(TokW),
    .Depth(TokQDepth)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tq_push),
    .data_i  (tq_wtok),
    .full_o  (tq_full),
    .pop_i   (tq_pop),
    .valid_o (tq_valid),
    .data_o  (tq_rdata)
  );

  jpt_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tq_valid),
    .tok_i       (tok_t'(tq_rdata)),
    .space_i     (rb_space),
    .pop_o       (tq_pop),
    .push_o      (rb_push)
  );

  jpt_res_buf u_res_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (rb_push),
    .space_o  (rb_space),
    .result_o (result_o)
  );

endmodule

FILE: tb/tb_json_path_tokenizer.sv
// testbench for json_path_tokenizer: directed paths from a table, then random paths
// checked against a local path parser; depends on jpt_pkg, jpt_if and the design
`timescale 1ns / 1ps

module tb_json_path_tokenizer;
  import jpt_pkg::*;

  localparam int unsigned MaxSlots    = DefMaxSlots;
  localparam int unsigned MaxPathLen  = DefMaxPathLen;
  localparam int unsigned RandomChars = 560;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 5000;
  localparam logic [7:0]  ChPad       = 8'h61;

  typedef struct {
    string        text;
    int unsigned  pad;
    bit           typed;
    result_kind_e kind;
    int unsigned  count;
  } path_case_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jpt_char_if   char_if ();
  jpt_result_if res_if ();

  json_path_tokenizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .result_o(res_if)
  );

  always #10 clk_i = ~clk_i;

  // parser state
  phase_e           st_phase;
  int unsigned      st_pos;
  int unsigned      st_sections;
  int unsigned      sec_start;
  int unsigned      sec_len;
  bit               sec_has_index;
  bit               sec_all;
  bit               num_negative;
  bit               num_seen;
  longint unsigned  num_value;

  result_t     char_results[$];
  result_t     pending_results[$];
  logic [7:0]  path_chars[$];
  int unsigned chars_sent = 0;
  int          fail_count = 0;
  int unsigned idle_mode  = 0;
  int unsigned calm_left [2] = '{0, 0};
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned quiet_cycles = 0;
  string       junk_chars = "/[]*+- 09x";

  path_case_t directed_paths [22] = '{
    '{"",                            0,    1, RK_SYNTAX,  0},
    '{"abc",                         0,    1, RK_SYNTAX,  0},
    '{"/",                           0,    1, RK_DONE,    0},
    '{"//",                          0,    1, RK_SYNTAX,  0},
    '{"/a/",                         0,    0, RK_SECTION, 0},
    '{"/store/book[3]/title",        0,    0, RK_SECTION, 0},
    '{"/[]/x[*]",                    0,    0, RK_SECTION, 0},
    '{"/[\013\014\015\012\011 +12]", 0,    0, RK_SECTION, 0},
    '{"/a[-0]",                      0,    0, RK_SECTION, 0},
    '{"/a[-1]",                      0,    1, RK_SYNTAX,  0},
    '{"/a[007]/b[2147483647]",       0,    0, RK_SECTION, 0},
    '{"/a[2147483648]",              0,    1, RK_SYNTAX,  0},
    '{"/a[*x]",                      0,    1, RK_SYNTAX,  0},
    '{"/a[3]b",                      0,    1, RK_SYNTAX,  0},
    '{"/a[+]",                       0,    1, RK_SYNTAX,  0},
    '{"/a[ ]",                       0,    1, RK_SYNTAX,  0},
    '{"/a[",                         0,    1, RK_SYNTAX,  0},
    '{"/a[12",                       0,    1, RK_SYNTAX,  0},
    '{"/a/b/c/d/e/f/g",              0,    0, RK_SECTION, 0},
    '{"/a/b/c/d/e/f/g/h",            0,    0, RK_SECTION, 0},
    '{"/\377\200~ ]*",               0,    0, RK_SECTION, 0},
    '{"/ok",                         0,    0, RK_SECTION, 0}
  };

  function automatic bit is_num(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic void clear_section();
    sec_start     = 0;
    sec_len       = 0;
    sec_has_index = 1'b0;
    sec_all       = 1'b1;
    num_negative  = 1'b0;
    num_seen      = 1'b0;
    num_value     = 0;
  endfunction

  function automatic void restart_path();
    st_phase    = PH_SLASH;
    st_pos      = 0;
    st_sections = 0;
    clear_section();
  endfunction

  function automatic void open_index();
    sec_has_index = 1'b1;
    sec_all       = 1'b1;
    num_negative  = 1'b0;
    num_seen      = 1'b0;
    num_value     = 0;
    st_phase      = PH_OPEN;
  endfunction

  function automatic void emit(result_kind_e kind);
    result_t r;
    r = '0;
    r.result_kind = kind;
    r.last        = (kind != RK_SECTION);
    if (kind == RK_DONE) r.section_count = 3'(st_sections);
    if (kind == RK_SECTION) begin
      r.section_number = 3'(st_sections);
      r.name_start     = FieldW'(sec_start);
      r.name_len       = FieldW'(sec_len);
      r.has_index      = sec_has_index;
      r.all_indexes    = sec_all;
      r.index_value    = sec_all ? '0 : IndexW'(num_value);
    end
    char_results.push_back(r);
  endfunction

  function automatic void raise_error(result_kind_e kind, logic [7:0] c);
    emit(kind);
    if (c == ChNul) restart_path();
    else st_phase = PH_SKIP;
  endfunction

  function automatic void close_path();
    emit(RK_DONE);
    restart_path();
  endfunction

  function automatic void close_section(logic [7:0] c);
    if (st_sections >= MaxSlots - 1) begin
      raise_error(RK_TOOMANY, c);
    end else begin
      emit(RK_SECTION);
      st_sections++;
      if (c == ChNul) begin
        close_path();
      end else begin
        clear_section();
        st_phase = PH_SEC;
      end
    end
  endfunction

  // one path character through the parser, results land in char_results
  function automatic void tokenize_char(logic [7:0] c);
    int unsigned     pos;
    longint unsigned v;
    pos = st_pos;
    if (st_phase == PH_SKIP) begin
      if (c == ChNul) restart_path();
      return;
    end
    if (c != ChNul && pos >= MaxPathLen) begin
      raise_error(RK_TOOLONG, c);
      return;
    end
    if (c != ChNul) st_pos = pos + 1;
    case (st_phase)
      PH_SLASH: begin
        if (c == ChSlash) st_phase = PH_SEC;
        else raise_error(RK_SYNTAX, c);
      end
      PH_SEC: begin
        if (c == ChNul) begin
          close_path();
        end else if (c == ChSlash) begin
          raise_error(RK_SYNTAX, c);
        end else begin
          clear_section();
          sec_start = pos;
          if (c == ChLBrack) begin
            open_index();
          end else begin
            sec_len  = 1;
            st_phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (c == ChNul || c == ChSlash) close_section(c);
        else if (c == ChLBrack) open_index();
        else sec_len++;
      end
      PH_OPEN, PH_WS: begin
        if (st_phase == PH_OPEN && c == ChRBrack) begin
          st_phase = PH_AFTER;
        end else if (st_phase == PH_OPEN && c == ChStar) begin
          st_phase = PH_STAR;
        end else if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
          st_phase = PH_WS;
        end else if (c == ChPlus || c == ChMinus) begin
          num_negative = (c == ChMinus);
          st_phase     = PH_NUM;
        end else if (is_num(c)) begin
          st_phase  = PH_NUM;
          num_seen  = 1'b1;
          num_value = c - ChZero;
        end else begin
          raise_error(RK_SYNTAX, c);
        end
      end
      PH_STAR: begin
        if (c == ChRBrack) st_phase = PH_AFTER;
        else raise_error(RK_SYNTAX, c);
      end
      PH_NUM: begin
        if (is_num(c)) begin
          v = num_value * 10 + (c - ChZero);
          if ((num_negative && c != ChZero) || v > 64'h7FFF_FFFF) begin
            raise_error(RK_SYNTAX, c);
          end else begin
            num_value = v;
            num_seen  = 1'b1;
          end
        end else if (c == ChRBrack && num_seen) begin
          sec_all  = 1'b0;
          st_phase = PH_AFTER;
        end else begin
          raise_error(RK_SYNTAX, c);
        end
      end
      PH_AFTER: begin
        if (c == ChNul || c == ChSlash) close_section(c);
        else raise_error(RK_SYNTAX, c);
      end
      default: raise_error(RK_SYNTAX, c);
    endcase
  endfunction

  // per-cycle idle decision with occasional calm stretches
  function automatic bit idle_now(bit recv);
    int unsigned pct;
    pct = (idle_mode == 0) ? (recv ? 67 : 37) : (idle_mode == 1) ? (recv ? 37 : 67) : 0;
    if (calm_left[recv] > 0) begin
      calm_left[recv]--;
      return 1'b0;
    end
    if ($urandom_range(0, 99) == 0) calm_left[recv] = $urandom_range(20, 80);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic build_random_path();
    int unsigned     nsec;
    int unsigned     nlen;
    int unsigned     form;
    int unsigned     sign;
    longint unsigned val;
    string           digits;
    logic [7:0]      c;
    path_chars.delete();
    if ($urandom_range(0, 99) < 20) begin
      if ($urandom_range(0, 1)) path_chars.push_back(ChSlash);
      repeat ($urandom_range(0, 10)) path_chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      path_chars.push_back(ChSlash);
      nsec = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 4);
      for (int s = 0; s < nsec; s++) begin
        if (s > 0) path_chars.push_back(ChSlash);
        nlen = $urandom_range(0, 5);
        form = (nlen == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3);
        repeat (nlen) begin
          do begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(1, 255));
          end while (c == ChSlash || c == ChLBrack);
          path_chars.push_back(c);
        end
        if (form != 0) path_chars.push_back(ChLBrack);
        if (form == 2) path_chars.push_back(ChStar);
        if (form == 3) begin
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
              path_chars.push_back($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13)));
          end
          sign = $urandom_range(0, 7);
          case ($urandom_range(0, 4))
            0:       val = $urandom_range(0, 9);
            1:       val = $urandom_range(10, 100000);
            2:       val = 64'd2147483647 - $urandom_range(0, 2);
            3:       val = 64'd2147483648 + $urandom_range(0, 1000);
            default: val = $urandom();
          endcase
          if (sign == 0) path_chars.push_back(ChPlus);
          if (sign == 1) begin
            path_chars.push_back(ChMinus);
            val = $urandom_range(0, 3) == 0;
          end
          digits = $sformatf("%0d", val);
          if ($urandom_range(0, 4) == 0) digits = {"00", digits};
          for (int i = 0; i < digits.len(); i++) path_chars.push_back(digits[i]);
        end
        if (form != 0) path_chars.push_back(ChRBrack);
      end
      if ($urandom_range(0, 9) == 0) path_chars.push_back(ChSlash);
      if ($urandom_range(0, 4) == 0) begin
        c = $urandom_range(0, 2) == 0 ? 8'($urandom_range(1, 255))
                                      : junk_chars[$urandom_range(0, junk_chars.len() - 1)];
        path_chars[$urandom_range(0, path_chars.size() - 1)] = c;
      end
    end
    path_chars.push_back(ChNul);
  endtask

  // offer every character of path_chars and record the results it causes
  task automatic send_path(bit typed, result_t typed_res);
    result_t r;
    foreach (path_chars[i]) begin
      while (idle_now(1'b0)) begin
        char_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      char_if.valid <= 1'b1;
      char_if.ch    <= path_chars[i];
      do @(posedge clk_i); while (!char_if.ready);
      tokenize_char(path_chars[i]);
      while (char_results.size() > 0) begin
        r = char_results.pop_front();
        pending_results.push_back((typed && r.last) ? typed_res : r);
      end
      chars_sent++;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(result_t want);
    check_field("result_kind", 32'(want.result_kind), 32'(res_if.result_kind));
    check_field("section_number", 32'(want.section_number), 32'(res_if.section_number));
    check_field("name_start", 32'(want.name_start), 32'(res_if.name_start));
    check_field("name_len", 32'(want.name_len), 32'(res_if.name_len));
    check_field("has_index", 32'(want.has_index), 32'(res_if.has_index));
    check_field("all_indexes", 32'(want.all_indexes), 32'(res_if.all_indexes));
    check_field("index_value", 32'(want.index_value), 32'(res_if.index_value));
    check_field("section_count", 32'(want.section_count), 32'(res_if.section_count));
    check_field("last", 32'(want.last), 32'(res_if.last));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", res_if.result_kind);
        fail_count++;
      end else begin
        check_result(pending_results.pop_front());
      end
    end
  end

  // receiver, with one long hold-off at the start of the random part
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      res_if.ready <= !idle_now(1'b1);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    result_t     typed_res;
    int unsigned random_base;
    char_if.valid <= 1'b0;
    char_if.ch    <= ChNul;
    restart_path();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_paths[k]) begin
      path_chars.delete();
      for (int i = 0; i < directed_paths[k].text.len(); i++)
        path_chars.push_back(directed_paths[k].text[i]);
      repeat (directed_paths[k].pad) path_chars.push_back(ChPad);
      path_chars.push_back(ChNul);
      typed_res               = '0;
      typed_res.result_kind   = directed_paths[k].kind;
      typed_res.section_count = 3'(directed_paths[k].count);
      typed_res.last          = 1'b1;
      send_path(directed_paths[k].typed, typed_res);
    end

    random_base = chars_sent;
    hold_req    = 1'b1;
    while (chars_sent - random_base < RandomChars) begin
      idle_mode = (chars_sent - random_base) * 3 / RandomChars;
      build_random_path();
      send_path(1'b0, typed_res);
    end
    char_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
